// ===== hdl/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared types and codes for the ready-queue CPU scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CPU_COUNT_DEF   = 8;

    localparam logic [1:0] OP_WAKE     = 2'd0;
    localparam logic [1:0] OP_PREEMPT  = 2'd1;
    localparam logic [1:0] OP_SCHEDULE = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] KIND_ENQ      = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_PREEMPT  = 2'd2;

    localparam logic [1:0] MODE_RR     = 2'd1;
    localparam logic [1:0] MODE_STATIC = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SLICE  = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CRD  = 13'b0000000000010,
        S_CRW  = 13'b0000000000100,
        S_ENQ  = 13'b0000000001000,
        S_SCRD = 13'b0000000010000,
        S_SCCK = 13'b0000000100000,
        S_SHRD = 13'b0000001000000,
        S_SHWR = 13'b0000010000000,
        S_INS  = 13'b0000100000000,
        S_VRD  = 13'b0001000000000,
        S_VCK  = 13'b0010000000000,
        S_DQ   = 13'b0100000000000,
        S_DQWR = 13'b1000000000000
    } t_state;

endpackage

// ===== hdl/ready_queue_cpu_scheduler.sv =====
// ----------------------------------------------------------------------------
// ready_queue_cpu_scheduler
// Ready queue and per-CPU run state; wake, preempt and schedule requests.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one request: op, proc_id,
// priority_req, cpu_id. Output channel (o_out_valid / i_out_ready) returns
// exactly one result per request. A single sequencer walks the request over
// one queue memory port and one CPU memory port, one entry per step.
// Steps: a wake enqueues; a schedule dispatches from the queue head; a preempt
// of a busy CPU first reads its run entry and requeues that process (skipped,
// with overflow, when the queue is full), then dispatches. In static mode the
// sorted insert reads and checks each entry scanned and reads and writes each
// entry moved, and a wake then scans the active CPUs one at a time.
// A new request is taken only when the sequencer is idle and holds no result;
// the result register lets it accept the next request while a result waits.
// If the receiver stalls, a finished result waits in the sequencer until the
// result register frees. Reset (synchronous, active low) empties the queue,
// marks every CPU idle and restores the register defaults; no clearing pass.
// Config writes are taken at any edge with i_cfg_we high.
// ----------------------------------------------------------------------------
module ready_queue_cpu_scheduler #(
    parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH_DEF,
    parameter int CPU_COUNT   = rqs_pkg::CPU_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_proc_id,
    input  logic [3:0]  i_priority_req,
    input  logic [2:0]  i_cpu_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_out_cpu,
    output logic [7:0]  o_out_proc,
    output logic        o_out_proc_valid,
    output logic [15:0] o_out_slice,
    output logic        o_overflow
);
    import rqs_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int LIM = (CPU_COUNT < 8) ? CPU_COUNT : 8;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW:0]   lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx[AW-1:0]};
        if (s >= DEPTH_C) s = s - DEPTH_C;
        return s[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] cidx(input logic [3:0] c);
        logic [63:0] t;
        t = {60'd0, c};
        return t[CW-1:0];
    endfunction

    // config
    logic [1:0]  r_mode;
    logic [15:0] r_slice;
    logic [3:0]  r_active;

    // storage
    logic [11:0] qmem [QUEUE_DEPTH];
    logic [11:0] cmem [CPU_COUNT];
    logic [11:0] r_qrd, r_crd;
    logic [CPU_COUNT-1:0] r_busy;
    logic [AW-1:0] r_head;
    logic [AW:0]   r_count;

    // sequencer
    t_state r_state, n_state;
    logic [1:0] r_op;
    logic [2:0] r_cpu;
    logic [7:0] r_en_proc;
    logic [3:0] r_en_prio;
    logic [AW:0] r_pos, r_i;
    logic [3:0]  r_vi;
    logic [2:0]  r_low;
    logic [3:0]  r_low_prio;
    logic        r_done;

    // pending result
    logic [1:0]  r_kind;
    logic [2:0]  r_rcpu;
    logic [7:0]  r_rproc;
    logic        r_rpv;
    logic [15:0] r_rslice;
    logic        r_rovf;

    // output register
    logic        r_ov;
    logic [1:0]  r_okind;
    logic [2:0]  r_ocpu;
    logic [7:0]  r_oproc;
    logic        r_opv;
    logic [15:0] r_oslice;
    logic        r_oovf;

    logic [3:0]  ncpu;
    logic        q_re, q_we, c_re, c_we;
    logic [AW-1:0] q_raddr, q_waddr;
    logic [CW-1:0] c_raddr, c_waddr;
    logic [11:0] q_wdata, c_wdata;
    logic        out_free, accept;

    always_comb begin
        ncpu = (r_active == 4'd0) ? 4'd1 : r_active;
        if (32'(ncpu) > LIM) ncpu = 4'(LIM);
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_done;
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;

    // memory port control
    always_comb begin
        q_re = 1'b0; q_we = 1'b0; c_re = 1'b0; c_we = 1'b0;
        q_raddr = phys(r_head, r_pos);
        q_waddr = phys(r_head, r_pos);
        q_wdata = {r_en_proc, r_en_prio};
        c_raddr = cidx({1'b0, r_cpu});
        c_waddr = cidx({1'b0, r_cpu});
        c_wdata = r_qrd;
        unique case (r_state)
            S_CRD:  c_re = 1'b1;
            S_SCRD: q_re = 1'b1;
            S_SHRD: begin
                q_re    = r_i > r_pos;
                q_raddr = phys(r_head, r_i - 1'b1);
            end
            S_SHWR: begin
                q_we    = 1'b1;
                q_waddr = phys(r_head, r_i);
                q_wdata = r_qrd;
            end
            S_INS:  q_we = 1'b1;
            S_VRD: begin
                c_re    = 1'b1;
                c_raddr = cidx(r_vi);
            end
            S_DQ: begin
                q_re    = 1'b1;
                q_raddr = r_head;
            end
            S_DQWR: c_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_we) qmem[q_waddr] <= q_wdata;
        if (q_re) r_qrd <= qmem[q_raddr];
        if (c_we) cmem[c_waddr] <= c_wdata;
        if (c_re) r_crd <= cmem[c_raddr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_WAKE) begin
                        n_state = S_ENQ;
                    end else if ((i_op == OP_PREEMPT || i_op == OP_SCHEDULE)
                                 && ({1'b0, i_cpu_id} < ncpu)) begin
                        if (i_op == OP_PREEMPT && r_busy[cidx({1'b0, i_cpu_id})])
                            n_state = S_CRD;
                        else
                            n_state = S_DQ;
                    end
                end
            end
            S_CRD:  n_state = S_CRW;
            S_CRW:  n_state = S_ENQ;
            S_ENQ: begin
                if (r_count == DEPTH_C)
                    n_state = (r_op == OP_WAKE) ? S_IDLE : S_DQ;
                else if (r_mode == MODE_STATIC && r_count != '0)
                    n_state = S_SCRD;
                else
                    n_state = S_SHRD;
            end
            S_SCRD: n_state = S_SCCK;
            S_SCCK: begin
                if (r_qrd[3:0] >= r_en_prio && (r_pos + 1'b1) < r_count)
                    n_state = S_SCRD;
                else
                    n_state = S_SHRD;
            end
            S_SHRD: n_state = (r_i > r_pos) ? S_SHWR : S_INS;
            S_SHWR: n_state = S_SHRD;
            S_INS: begin
                if (r_op != OP_WAKE)           n_state = S_DQ;
                else if (r_mode == MODE_STATIC) n_state = S_VRD;
                else                            n_state = S_IDLE;
            end
            S_VRD: begin
                if (r_vi == ncpu || !r_busy[cidx(r_vi)]) n_state = S_IDLE;
                else                                     n_state = S_VCK;
            end
            S_VCK:  n_state = S_VRD;
            S_DQ:   n_state = (r_count == '0) ? S_IDLE : S_DQWR;
            S_DQWR: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // r_done marks a finished result waiting for the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_ov     <= 1'b0;
            r_busy   <= '0;
            r_count  <= '0;
            r_head   <= '0;
            r_mode   <= 2'd0;
            r_slice  <= 16'd0;
            r_active <= 4'd1;
        end else begin
            if (i_cfg_we) begin
                priority case (i_cfg_addr)
                    CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    CFG_SLICE:  r_slice  <= i_cfg_data;
                    CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            r_state <= n_state;
            if (r_done && out_free) begin
                r_done   <= 1'b0;
                r_ov     <= 1'b1;
                r_okind  <= r_kind;
                r_ocpu   <= r_rcpu;
                r_oproc  <= r_rproc;
                r_opv    <= r_rpv;
                r_oslice <= r_rslice;
                r_oovf   <= r_rovf;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state != S_IDLE && n_state == S_IDLE) r_done <= 1'b1;
            if (accept && n_state == S_IDLE) r_done <= 1'b1;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_op;
                        r_cpu     <= i_cpu_id;
                        r_en_proc <= i_proc_id;
                        r_en_prio <= i_priority_req;
                        r_kind    <= KIND_ENQ;
                        r_rcpu    <= 3'd0;
                        r_rproc   <= 8'd0;
                        r_rpv     <= 1'b0;
                        r_rslice  <= 16'd0;
                        r_rovf    <= 1'b0;
                    end
                end
                S_CRW: begin
                    r_en_proc <= r_crd[11:4];
                    r_en_prio <= r_crd[3:0];
                    r_busy[cidx({1'b0, r_cpu})] <= 1'b0;
                end
                S_ENQ: begin
                    if (r_count == DEPTH_C) r_rovf <= 1'b1;
                    r_i <= r_count;
                    r_pos <= (r_mode == MODE_STATIC) ? '0 : r_count;
                end
                S_SCCK: begin
                    if (r_qrd[3:0] >= r_en_prio) r_pos <= r_pos + 1'b1;
                end
                S_SHWR: r_i <= r_i - 1'b1;
                S_INS: begin
                    r_count <= r_count + 1'b1;
                    r_vi    <= 4'd0;
                end
                S_VRD: begin
                    if (r_vi == ncpu && r_low_prio < r_en_prio) begin
                        r_kind <= KIND_PREEMPT;
                        r_rcpu <= r_low;
                    end
                end
                S_VCK: begin
                    if (r_vi == 4'd0 || r_crd[3:0] < r_low_prio) begin
                        r_low      <= r_vi[2:0];
                        r_low_prio <= r_crd[3:0];
                    end
                    r_vi <= r_vi + 1'b1;
                end
                S_DQ: begin
                    r_kind   <= KIND_DISPATCH;
                    r_rcpu   <= r_cpu;
                    r_rslice <= (r_mode == MODE_RR) ? r_slice : 16'd0;
                    if (r_count == '0) r_busy[cidx({1'b0, r_cpu})] <= 1'b0;
                end
                S_DQWR: begin
                    r_busy[cidx({1'b0, r_cpu})] <= 1'b1;
                    r_head  <= phys(r_head, (AW + 1)'(1));
                    r_count <= r_count - 1'b1;
                    r_rproc <= r_qrd[11:4];
                    r_rpv   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_kind           = r_okind;
    assign o_out_cpu        = r_ocpu;
    assign o_out_proc       = r_oproc;
    assign o_out_proc_valid = r_opv;
    assign o_out_slice      = r_oslice;
    assign o_overflow       = r_oovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C) else $error("queue count beyond depth");

    a_nondispatch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_okind != KIND_DISPATCH) |-> (!r_opv && r_oslice == 16'd0))
        else $error("non-dispatch result carries dispatch fields");

    a_busy_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DQWR) |=> (r_busy[cidx({1'b0, r_cpu})] && r_rpv))
        else $error("dispatch did not mark cpu busy");

    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready) else $error("request taken while busy");

endmodule
